// ----- rtl/pfrc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfrc_pkg
// Shared types, register indexes and sample coding for the PCM format and
// rate converter.
// ----------------------------------------------------------------------------
package pfrc_pkg;

    localparam int RATE_W   = 18;
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 32;
    localparam int ADDR_W   = 3;

    localparam logic [ADDR_W-1:0] CFG_SRC_IS_16BIT  = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_DST_IS_16BIT  = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_SRC_IS_STEREO = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_DST_IS_STEREO = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_SRC_RATE      = 3'd4;
    localparam logic [ADDR_W-1:0] CFG_DST_RATE      = 3'd5;

    localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Divider handshake status
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Raw source sample to destination coding. Offset binary and two's
    // complement differ only in the top bit, so width changes reduce to
    // byte moves with that bit flipped.
    function automatic sample_t convert_sample(input sample_t raw,
                                               input logic src16,
                                               input logic dst16);
        sample_t res;
        unique case ({src16, dst16})
            2'b11:   res = raw;
            2'b10:   res = {8'h00, raw[15] ^ 1'b1, raw[14:8]};
            2'b01:   res = {raw[7] ^ 1'b1, raw[6:0], 8'h00};
            default: res = {8'h00, raw[7:0]};
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/pfrc_divider.sv -----
// ----------------------------------------------------------------------------
// pfrc_divider
// Radix-2 restoring divider: one shared subtractor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pfrc_divider #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 18
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     dividend,
    input  logic [DEN_W-1:0]     divisor,
    output logic [NUM_W-1:0]     quotient,
    output pfrc_pkg::div_status_t stat
);
    import pfrc_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    assign trial = {rem_reg, quo_reg[NUM_W-1]} - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            den_next  = divisor;
            quo_next  = dividend;
            cnt_next  = CW'(NUM_W);
            done_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[DEN_W])
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DEN_W-2:0], quo_reg[NUM_W-1]};
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

// ----- rtl/pcm_format_rate_converter.sv -----
// ----------------------------------------------------------------------------
// pcm_format_rate_converter
// Converts PCM frames between sample widths and channel counts and tags each
// frame with its destination frame index, rounded down.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_t*): one source frame per item, left sample in
//   s_tdata[15:0], right sample in s_tdata[31:16], s_tlast on the final frame
//   of a buffer. The frame counter restarts after an item with s_tlast.
//   Output stream (m_t*): one result per item: destination index, converted
//   left and right samples in m_tdata, right_valid in m_tuser, end of buffer
//   in m_tlast.
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 source
//   16-bit, 1 destination 16-bit, 2 source stereo, 3 destination stereo,
//   4 source rate, 5 destination rate); write only while the block is idle.
//   Sequence: each item passes through the MUL, LOAD and DIV states, where
//   the one-bit-a-cycle divider forms index * dst_rate / src_rate. s_tready
//   is high only between items, so a new item is not taken until the previous
//   one has been moved to the output register.
//   A new item may be accepted while the previous result still waits in the
//   output register; a stalled receiver holds the result and the block waits
//   at the end of the next division. Reset clears the frame counter, empties
//   the output register and loads the register defaults (16-bit stereo on
//   both sides, 44100 samples per second).
// ----------------------------------------------------------------------------
module pcm_format_rate_converter #(
    parameter int FRAME_INDEX_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // left_in, right_in
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,   // dest_index, left_out, right_out
    output logic                        m_tuser,   // right_valid
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic [pfrc_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [pfrc_pkg::RATE_W-1:0] cfg_wdata
);
    import pfrc_pkg::*;

    localparam int PROD_W = FRAME_INDEX_BITS + RATE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic                        src16_reg, dst16_reg, srcst_reg, dstst_reg;
    logic [RATE_W-1:0]           src_rate_reg, dst_rate_reg;
    logic [1:0]                  state_reg, state_next;
    logic [FRAME_INDEX_BITS-1:0] count_reg, count_next;
    logic [FRAME_INDEX_BITS-1:0] idx_reg;
    logic [PROD_W-1:0]           prod_reg;
    sample_t                     left_reg, right_reg;
    logic                        rvalid_reg, last_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]          out_index_reg;
    sample_t                     out_left_reg, out_right_reg;
    logic                        out_rvalid_reg, out_last_reg;
    logic                        accept, load_out, div_start;
    sample_t                     conv_left, conv_right;
    logic [PROD_W-1:0]           quotient;
    div_status_t                 div_st;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign div_start = (state_reg == ST_LOAD);
    assign load_out  = (state_reg == ST_DIV) && div_st.done && (!out_valid_reg || m_tready);

    assign conv_left  = convert_sample(s_tdata[15:0], src16_reg, dst16_reg);
    assign conv_right = srcst_reg ? convert_sample(s_tdata[31:16], src16_reg, dst16_reg)
                                  : conv_left;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src16_reg    <= 1'b1;
            dst16_reg    <= 1'b1;
            srcst_reg    <= 1'b1;
            dstst_reg    <= 1'b1;
            src_rate_reg <= RATE_RESET;
            dst_rate_reg <= RATE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SRC_IS_16BIT:  src16_reg    <= cfg_wdata[0];
                CFG_DST_IS_16BIT:  dst16_reg    <= cfg_wdata[0];
                CFG_SRC_IS_STEREO: srcst_reg    <= cfg_wdata[0];
                CFG_DST_IS_STEREO: dstst_reg    <= cfg_wdata[0];
                CFG_SRC_RATE:      src_rate_reg <= cfg_wdata;
                CFG_DST_RATE:      dst_rate_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_MUL;
            ST_MUL:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = s_tlast ? '0 : count_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item payload, product and result holding
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg    <= count_reg;
            left_reg   <= conv_left;
            right_reg  <= dstst_reg ? conv_right : '0;
            rvalid_reg <= dstst_reg;
            last_reg   <= s_tlast;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(idx_reg) * PROD_W'(dst_rate_reg);
        end
        if (load_out)
        begin
            out_index_reg  <= (src_rate_reg == '0) ? '0 : quotient[INDEX_W-1:0];
            out_left_reg   <= left_reg;
            out_right_reg  <= right_reg;
            out_rvalid_reg <= rvalid_reg;
            out_last_reg   <= last_reg;
        end
    end

    pfrc_divider #(
        .NUM_W (PROD_W),
        .DEN_W (RATE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (src_rate_reg),
        .quotient (quotient),
        .stat     (div_st)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_right_reg, out_left_reg, out_index_reg};
    assign m_tuser  = out_rvalid_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/pfrc_checker.sv -----
// ----------------------------------------------------------------------------
// pfrc_checker
// Port-level checks for the PCM format and rate converter.
// ----------------------------------------------------------------------------
module pfrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // Busy after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after an accepted item");

    // A fresh result only appears while an item is in work
    a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised without an item in work");

    // Mono destination carries a zero right sample
    a_mono_right_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[63:48] == 16'h0000)
        else $error("right sample non-zero on a mono result");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind pcm_format_rate_converter pfrc_checker u_pfrc_checker (.*);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pcm_format_rate_converter. Source frames are queued
// by the stimulus process and driven in bursts with random gaps; each
// accepted frame is run through a local predictor of sample recoding and
// rounded-down destination index, and every result is compared field by field.
// Formats and rates are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pfrc_pkg::*;

    localparam int IDLE_PAUSE    = 64;
    localparam int LONG_HOLD     = 400;
    localparam int WATCHDOG      = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 125;

    typedef struct {
        sample_t left;
        sample_t right;
        logic    last;
    } src_frame_t;

    typedef struct {
        logic [INDEX_W-1:0] index;
        sample_t            left;
        sample_t            right;
        logic               rvalid;
        logic               eob;
    } conv_result_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [63:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              cfg_we    = 1'b0;
    logic [ADDR_W-1:0] cfg_addr  = '0;
    logic [RATE_W-1:0] cfg_wdata = '0;

    // Local copy of the format registers and the source frame counter
    logic               fmt_src16    = 1'b1;
    logic               fmt_dst16    = 1'b1;
    logic               fmt_src_st   = 1'b1;
    logic               fmt_dst_st   = 1'b1;
    logic [RATE_W-1:0]  fmt_src_rate = RATE_RESET;
    logic [RATE_W-1:0]  fmt_dst_rate = RATE_RESET;
    logic [INDEX_W-1:0] frame_count  = '0;

    src_frame_t   frame_queue[$];
    conv_result_t conv_expected[$];

    src_frame_t drv_frame;
    int         burst_left  = 0;
    int         gap_left    = 0;
    int         results_seen = 0;
    int         ready_pct   = 100;
    int         hold_left   = 0;
    int         holds_done  = 0;
    int         next_hold_at = 300;
    int         mismatches  = 0;
    int         idle_cycles = 0;

    logic [RATE_W-1:0] common_rates [8] = '{18'd8000, 18'd11025, 18'd22050, 18'd32000,
                                            18'd44100, 18'd48000, 18'd96000, 18'd192000};

    pcm_format_rate_converter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // left_in, right_in
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // dest_index, left_out, right_out
        .m_tuser   (m_tuser),     // right_valid
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Decode a raw sample in source coding and re-encode it in destination coding
    function automatic sample_t recode_sample(input sample_t raw);
        int v;
        int w;
        if (fmt_src16)
            v = fmt_dst16 ? int'($signed(raw)) : int'($signed(raw[15:8]));
        else
        begin
            v = int'(raw[7:0]) - 128;
            if (fmt_dst16)
                v = v * 256;
        end
        w = v + 128;
        if (fmt_dst16)
            return v[15:0];
        return {8'h00, w[7:0]};
    endfunction

    function automatic conv_result_t predict_frame(input src_frame_t f);
        conv_result_t r;
        sample_t      lft;
        sample_t      rgt;
        logic [63:0]  prod;
        logic [63:0]  quot;
        prod = 64'(frame_count) * 64'(fmt_dst_rate);
        quot = (fmt_src_rate == '0) ? 64'd0 : prod / 64'(fmt_src_rate);
        lft = recode_sample(f.left);
        rgt = fmt_src_st ? recode_sample(f.right) : lft;
        r.index  = quot[INDEX_W-1:0];
        r.left   = lft;
        r.right  = fmt_dst_st ? rgt : '0;
        r.rvalid = fmt_dst_st;
        r.eob    = f.last;
        frame_count = f.last ? '0 : frame_count + 1'b1;
        return r;
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        int unsigned k;
        k = $urandom_range(0, 9);
        case (k)
            0:       return '0;
            1:       return 18'd1;
            2:       return '1;
            3, 4, 5: return common_rates[3'($urandom_range(0, 7))];
            default: return RATE_W'($urandom_range(1, 192000));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 100)
            $display("ERROR: result %0d %s: got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    // Sender: bursts of items with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                conv_expected.push_back(predict_frame(drv_frame));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (frame_queue.size() != 0)
                begin
                    drv_frame = frame_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {drv_frame.right, drv_frame.left};
                    s_tlast  <= drv_frame.last;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs so the block backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (conv_expected.size() == 0)
                    report_mismatch("unexpected result", m_tdata, 64'd0);
                else
                begin
                    conv_result_t want;
                    want = conv_expected.pop_front();
                    if (m_tdata[31:0] !== want.index)
                        report_mismatch("dest_index", 64'(m_tdata[31:0]), 64'(want.index));
                    if (m_tdata[47:32] !== want.left)
                        report_mismatch("left_out", 64'(m_tdata[47:32]), 64'(want.left));
                    if (m_tdata[63:48] !== want.right)
                        report_mismatch("right_out", 64'(m_tdata[63:48]), 64'(want.right));
                    if (m_tuser !== want.rvalid)
                        report_mismatch("right_valid", 64'(m_tuser), 64'(want.rvalid));
                    if (m_tlast !== want.eob)
                        report_mismatch("end_of_buffer", 64'(m_tlast), 64'(want.eob));
                end
                results_seen++;
                if (results_seen % 150 == 0)
                begin
                    case ($urandom_range(0, 4))
                        0, 1:    ready_pct = 100;
                        2:       ready_pct = 75;
                        3:       ready_pct = 40;
                        default: ready_pct = 10;
                    endcase
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (holds_done < 2 && results_seen >= next_hold_at && frame_queue.size() > 8)
            begin
                hold_left = LONG_HOLD;
                holds_done++;
                next_hold_at += 400;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // Watchdog: give up when neither side moves an item for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG)
        begin
            $display("ERROR: no progress for %0d cycles", WATCHDOG);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_frame(input sample_t left, input sample_t right, input logic last);
        src_frame_t f;
        f.left  = left;
        f.right = right;
        f.last  = last;
        frame_queue.push_back(f);
    endtask

    // Hold until every queued item has been accepted and its result checked
    task automatic wait_idle();
        do
            @(negedge clk);
        while (frame_queue.size() != 0 || s_tvalid || conv_expected.size() != 0);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [RATE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic set_format(input logic src16, input logic dst16, input logic src_st,
                              input logic dst_st, input logic [RATE_W-1:0] src_rate,
                              input logic [RATE_W-1:0] dst_rate);
        wait_idle();
        write_reg(CFG_SRC_IS_16BIT, RATE_W'(src16));
        write_reg(CFG_DST_IS_16BIT, RATE_W'(dst16));
        write_reg(CFG_SRC_IS_STEREO, RATE_W'(src_st));
        write_reg(CFG_DST_IS_STEREO, RATE_W'(dst_st));
        write_reg(CFG_SRC_RATE, src_rate);
        write_reg(CFG_DST_RATE, dst_rate);
        cfg_we <= 1'b0;
        fmt_src16    = src16;
        fmt_dst16    = dst16;
        fmt_src_st   = src_st;
        fmt_dst_st   = dst_st;
        fmt_src_rate = src_rate;
        fmt_dst_rate = dst_rate;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset formats: 16-bit stereo both sides, equal rates
        push_frame(16'h0000, 16'hFFFF, 1'b0);
        push_frame(16'h7FFF, 16'h8000, 1'b0);
        push_frame(16'h8000, 16'h7FFF, 1'b0);
        push_frame(16'hFFFF, 16'h0001, 1'b1);
        push_frame(16'h1234, 16'hFEDC, 1'b0);

        // 16-bit to 8-bit, stereo source dropping to mono
        set_format(1'b1, 1'b0, 1'b1, 1'b0, 18'd48000, 18'd44100);
        push_frame(16'h7F80, 16'h1111, 1'b0);
        push_frame(16'h80FF, 16'hFFFF, 1'b0);
        push_frame(16'hFF00, 16'h8000, 1'b1);

        // 8-bit mono source to 16-bit stereo, slowest source against fastest destination
        set_format(1'b0, 1'b1, 1'b0, 1'b1, 18'd1, '1);
        push_frame(16'hAB00, 16'hFFFF, 1'b0);
        push_frame(16'h12FF, 16'h0000, 1'b0);
        push_frame(16'h0080, 16'h5555, 1'b0);
        push_frame(16'hFF7F, 16'hAAAA, 1'b1);

        // 8-bit stereo both sides with a zero source rate
        set_format(1'b0, 1'b0, 1'b1, 1'b1, 18'd0, 18'd192000);
        push_frame(16'hFF00, 16'h00FF, 1'b0);
        push_frame(16'h0080, 16'hFF7F, 1'b0);
        push_frame(16'h5A01, 16'hA5FE, 1'b1);

        // 16-bit mono both sides, fastest source against slowest destination
        set_format(1'b1, 1'b1, 1'b0, 1'b0, '1, 18'd1);
        push_frame(16'h8001, 16'h7FFE, 1'b0);
        push_frame(16'h0100, 16'hFFFF, 1'b0);
        push_frame(16'hFFFF, 16'h0000, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_format(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       pick_rate(), pick_rate());
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_frame(sample_t'($urandom), sample_t'($urandom),
                           $urandom_range(0, 19) == 0);
        end

        wait_idle();
        if (mismatches == 0 && conv_expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pfrc_pkg.sv
rtl/pfrc_divider.sv
rtl/pcm_format_rate_converter.sv
rtl/pfrc_checker.sv
test/testbench.sv
